// ===== rtl/affine_cipher_alphabet_core_defines.svh =====
// Assertion helpers shared by aca_key_unit and aca_pipe
`ifndef AFFINE_CIPHER_ALPHABET_CORE_DEFINES_SVH
`define AFFINE_CIPHER_ALPHABET_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define ACA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aca: assertion failed");

// Next-cycle implication, disabled while reset is low
`define ACA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aca: assertion failed");

`endif

// ===== rtl/aca_pkg.sv =====
`default_nettype none

package aca_pkg;

  // Alphabet sizes (both prime)
  localparam logic [6:0] SIZE_ENG = 7'd71;
  localparam logic [6:0] SIZE_CYR = 7'd83;

  // Index of the first digit in each alphabet
  localparam logic [6:0] BASE_ENG = 7'd52;
  localparam logic [6:0] BASE_CYR = 7'd64;

  // Reciprocals for mod-by-constant: q = (p * RECIP) >> RECIP_SHIFT, exact for p < 8192
  localparam logic [12:0] RECIP_ENG   = 13'd7385;
  localparam logic [12:0] RECIP_CYR   = 13'd6317;
  localparam int          RECIP_SHIFT = 19;

  // Character codes
  localparam logic [15:0] CH_NEWLINE = 16'h000A;
  localparam logic [15:0] CH_UP_A    = 16'h0041;
  localparam logic [15:0] CH_UP_Z    = 16'h005A;
  localparam logic [15:0] CH_LO_A    = 16'h0061;
  localparam logic [15:0] CH_LO_Z    = 16'h007A;
  localparam logic [15:0] CH_DIG_0   = 16'h0030;
  localparam logic [15:0] CH_DIG_9   = 16'h0039;
  localparam logic [15:0] CH_CYR_LO0 = 16'h0430;
  localparam logic [15:0] CH_CYR_LO1 = 16'h044F;
  localparam logic [15:0] CH_CYR_UP0 = 16'h0410;
  localparam logic [15:0] CH_CYR_UP1 = 16'h042F;
  localparam logic [15:0] CH_COMMA   = 16'h002C;
  localparam logic [15:0] CH_PERIOD  = 16'h002E;
  localparam logic [15:0] CH_SPACE   = 16'h0020;
  localparam logic [15:0] CH_EXCL    = 16'h0021;
  localparam logic [15:0] CH_QUEST   = 16'h003F;
  localparam logic [15:0] CH_SEMI    = 16'h003B;
  localparam logic [15:0] CH_COLON   = 16'h003A;
  localparam logic [15:0] CH_DQUOTE  = 16'h0022;
  localparam logic [15:0] CH_SQUOTE  = 16'h0027;

  // Configuration register indexes
  localparam logic [1:0] REG_LANGUAGE   = 2'd0;
  localparam logic [1:0] REG_DIRECTION  = 2'd1;
  localparam logic [1:0] REG_MULTIPLIER = 2'd2;
  localparam logic [1:0] REG_SHIFT      = 2'd3;

  // Key values derived from the configuration
  typedef struct packed {
    logic       ok;
    logic [6:0] mult_mod;
    logic [6:0] shift_mod;
    logic [6:0] inv;
  } key_t;

  function automatic logic [6:0] alpha_size(input logic lang);
    return lang ? SIZE_CYR : SIZE_ENG;
  endfunction

  // Character code to alphabet index, 0 when absent
  function automatic logic [6:0] char_to_index(input logic [15:0] c, input logic lang);
    logic [6:0] base;
    logic [6:0] idx;
    base = lang ? BASE_CYR : BASE_ENG;
    idx  = 7'd0;
    if (lang && c >= CH_CYR_LO0 && c <= CH_CYR_LO1) begin
      idx = 7'(c - CH_CYR_LO0);
    end else if (lang && c >= CH_CYR_UP0 && c <= CH_CYR_UP1) begin
      idx = 7'd32 + 7'(c - CH_CYR_UP0);
    end else if (!lang && c >= CH_UP_A && c <= CH_UP_Z) begin
      idx = 7'(c - CH_UP_A);
    end else if (!lang && c >= CH_LO_A && c <= CH_LO_Z) begin
      idx = 7'd26 + 7'(c - CH_LO_A);
    end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
      idx = base + 7'(c - CH_DIG_0);
    end else begin
      unique case (c)
        CH_COMMA:  idx = base + 7'd10;
        CH_PERIOD: idx = base + 7'd11;
        CH_SPACE:  idx = base + 7'd12;
        CH_EXCL:   idx = base + 7'd13;
        CH_QUEST:  idx = base + 7'd14;
        CH_SEMI:   idx = base + 7'd15;
        CH_COLON:  idx = base + 7'd16;
        CH_DQUOTE: idx = base + 7'd17;
        CH_SQUOTE: idx = base + 7'd18;
        default:   idx = 7'd0;
      endcase
    end
    return idx;
  endfunction

  // Alphabet index (below size) to character code
  function automatic logic [15:0] index_to_char(input logic [6:0] idx, input logic lang);
    logic [6:0]  base;
    logic [6:0]  off;
    logic [15:0] ch;
    base = lang ? BASE_CYR : BASE_ENG;
    off  = idx - base;
    ch   = 16'h0000;
    if (lang && idx < 7'd32) begin
      ch = CH_CYR_LO0 + {9'b0, idx};
    end else if (lang && idx < 7'd64) begin
      ch = CH_CYR_UP0 + {9'b0, idx - 7'd32};
    end else if (!lang && idx < 7'd26) begin
      ch = CH_UP_A + {9'b0, idx};
    end else if (!lang && idx < 7'd52) begin
      ch = CH_LO_A + {9'b0, idx - 7'd26};
    end else if (idx >= base && off < 7'd10) begin
      ch = CH_DIG_0 + {9'b0, off};
    end else if (idx >= base) begin
      unique case (off)
        7'd10:   ch = CH_COMMA;
        7'd11:   ch = CH_PERIOD;
        7'd12:   ch = CH_SPACE;
        7'd13:   ch = CH_EXCL;
        7'd14:   ch = CH_QUEST;
        7'd15:   ch = CH_SEMI;
        7'd16:   ch = CH_COLON;
        7'd17:   ch = CH_DQUOTE;
        7'd18:   ch = CH_SQUOTE;
        default: ch = 16'h0000;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aca_key_unit.sv =====
`default_nettype none

// Derives multiplier mod size, shift mod size, key validity and the
// modular inverse after every configuration write.
module aca_key_unit
  import aca_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       reload,
  input  wire logic       lang,
  input  wire logic [9:0] mult,
  input  wire logic [9:0] shift,
  output key_t            key,
  output logic            busy
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_RED  = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_INV  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [9:0] mult_acc_r, mult_acc_nxt;
  logic [9:0] shift_acc_r, shift_acc_nxt;
  logic [1:0] step_r, step_nxt;
  logic [6:0] acc_r, acc_nxt;
  logic [6:0] x_r, x_nxt;
  key_t       key_r, key_nxt;

  logic [6:0] size;
  logic [9:0] sub;
  logic [7:0] acc_sum;

  assign size    = alpha_size(lang);
  assign sub     = 10'(size) << step_r;
  assign acc_sum = {1'b0, acc_r} + {1'b0, mult_acc_r[6:0]};

  // Sequencer: load, reduce by size*8..size*1, check, inverse search
  always_comb begin
    state_nxt     = state_r;
    mult_acc_nxt  = mult_acc_r;
    shift_acc_nxt = shift_acc_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    x_nxt         = x_r;
    key_nxt       = key_r;
    unique case (state_r)
      ST_IDLE: begin
      end
      ST_LOAD: begin
        mult_acc_nxt  = mult;
        shift_acc_nxt = shift;
        step_nxt      = 2'd3;
        state_nxt     = ST_RED;
      end
      ST_RED: begin
        if (mult_acc_r >= sub) begin
          mult_acc_nxt = mult_acc_r - sub;
        end
        if (shift_acc_r >= sub) begin
          shift_acc_nxt = shift_acc_r - sub;
        end
        step_nxt = step_r - 2'd1;
        if (step_r == 2'd0) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        key_nxt.mult_mod  = mult_acc_r[6:0];
        key_nxt.shift_mod = shift_acc_r[6:0];
        if (mult_acc_r[6:0] == 7'd0) begin
          // size is prime: only a multiple of it shares a factor
          key_nxt.ok  = 1'b0;
          key_nxt.inv = 7'd0;
          state_nxt   = ST_IDLE;
        end else begin
          acc_nxt   = mult_acc_r[6:0];
          x_nxt     = 7'd1;
          state_nxt = ST_INV;
        end
      end
      ST_INV: begin
        if (acc_r == 7'd1) begin
          key_nxt.ok  = 1'b1;
          key_nxt.inv = x_r;
          state_nxt   = ST_IDLE;
        end else begin
          acc_nxt = (acc_sum >= {1'b0, size}) ? 7'(acc_sum - {1'b0, size}) : acc_sum[6:0];
          x_nxt   = x_r + 7'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (reload) begin
      state_nxt = ST_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      key_r.ok          <= 1'b1;
      key_r.mult_mod    <= 7'd1;
      key_r.shift_mod   <= 7'd0;
      key_r.inv         <= 7'd1;
    end else begin
      state_r <= state_nxt;
      key_r   <= key_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    mult_acc_r  <= mult_acc_nxt;
    shift_acc_r <= shift_acc_nxt;
    step_r      <= step_nxt;
    acc_r       <= acc_nxt;
    x_r         <= x_nxt;
  end

  assign key  = key_r;
  assign busy = (state_r != ST_IDLE);

`include "affine_cipher_alphabet_core_defines.svh"

  `ACA_ASSERT_NXT(a_busy_after_write, clk, rst_n, reload, busy)
  `ACA_ASSERT_IMP(a_ok_matches_mult, clk, rst_n, !busy, key.ok == (key.mult_mod != 7'd0))
  `ACA_ASSERT_IMP(a_inv_in_range, clk, rst_n, !busy && key.ok, key.inv != 7'd0 && key.inv < size)

endmodule

`default_nettype wire

// ===== rtl/aca_pipe.sv =====
`default_nettype none

// Five-stage character pipeline: index, affine product, reciprocal
// quotient, remainder, character map.
module aca_pipe
  import aca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire logic [15:0] in_char,
  input  wire logic        lang,
  input  wire logic        dir,
  input  wire key_t        key,
  output logic             out_valid,
  output logic [15:0]      out_char,
  output logic             out_key_ok
);

  logic [6:0] size;
  logic [12:0] recip;
  assign size  = alpha_size(lang);
  assign recip = lang ? RECIP_CYR : RECIP_ENG;

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  logic        nl1_r, nl2_r, nl3_r, nl4_r;
  logic [6:0]  idx1_r;
  logic [12:0] p2_r, p3_r;
  logic [6:0]  q3_r;
  logic [6:0]  rem4_r;
  logic [15:0] char5_r;
  logic        ok5_r;

  // Stage 2 operands: encode idx*m + s, decode inv*(idx - s)
  logic [7:0]  diff;
  logic [6:0]  op_a, op_b, op_c;
  logic [13:0] p2_nxt;
  assign diff = (idx1_r >= key.shift_mod) ? {1'b0, idx1_r - key.shift_mod}
                                          : {1'b0, idx1_r} + {1'b0, size}
                                            - {1'b0, key.shift_mod};
  always_comb begin
    if (!dir) begin
      op_a = idx1_r;
      op_b = key.mult_mod;
      op_c = key.shift_mod;
    end else begin
      op_a = diff[6:0];
      op_b = key.inv;
      op_c = 7'd0;
    end
  end
  assign p2_nxt = (14'(op_a) * 14'(op_b)) + 14'(op_c);

  // Stage 3: quotient by reciprocal multiply
  logic [25:0] qprod;
  assign qprod = 26'(p2_r) * 26'(recip);

  // Stage 4: remainder with one correction step
  logic [13:0] qm;
  logic [13:0] r14;
  logic [13:0] rem_nxt;
  assign qm      = 14'(q3_r) * 14'(size);
  assign r14     = {1'b0, p3_r} - qm;
  assign rem_nxt = (r14 >= 14'(size)) ? r14 - 14'(size) : r14;

  // Stage 5: output character
  logic [15:0] char_nxt;
  always_comb begin
    if (!key.ok) begin
      char_nxt = 16'h0000;
    end else if (nl4_r) begin
      char_nxt = CH_NEWLINE;
    end else begin
      char_nxt = index_to_char(rem4_r, lang);
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Data stages
  always_ff @(posedge clk) begin
    idx1_r  <= char_to_index(in_char, lang);
    nl1_r   <= (in_char == CH_NEWLINE);
    p2_r    <= p2_nxt[12:0];
    nl2_r   <= nl1_r;
    p3_r    <= p2_r;
    q3_r    <= qprod[RECIP_SHIFT +: 7];
    nl3_r   <= nl2_r;
    rem4_r  <= rem_nxt[6:0];
    nl4_r   <= nl3_r;
    char5_r <= char_nxt;
    ok5_r   <= key.ok;
  end

  assign out_valid  = v5_r;
  assign out_char   = char5_r;
  assign out_key_ok = ok5_r;

`include "affine_cipher_alphabet_core_defines.svh"

  `ACA_ASSERT_IMP(a_word_arrives, clk, rst_n, in_fire, ##5 out_valid)
  `ACA_ASSERT_IMP(a_no_phantom, clk, rst_n, out_valid, $past(in_fire, 5))
  `ACA_ASSERT_IMP(a_rem_range, clk, rst_n, v4_r, rem4_r < size)

endmodule

`default_nettype wire

// ===== rtl/affine_cipher_alphabet_core.sv =====
`default_nettype none

// Channel  Handshake              Payload
// -------  ---------------------  ------------------------------------
// input    start & !busy          in_char[15:0]
// result   out_valid (1 cycle)    out_char[15:0], out_key_ok
// config   cfg_valid & cfg_ready  cfg_index[1:0], cfg_data[9:0]
//
// One word per cycle while busy is low; a taken word passes through the index,
// product, quotient, remainder and character stages. After a config write, busy
// stays high while the key unit reduces the key and searches the inverse.
// rst_n is synchronous; after reset the key is valid at once and busy is low.
// The result side cannot stall; the pipeline never holds a word.
module affine_cipher_alphabet_core
  import aca_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_char,
  output logic             out_valid,
  output logic [15:0]      out_char,
  output logic             out_key_ok,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  logic       lang_r;
  logic       dir_r;
  logic [9:0] mult_r;
  logic [9:0] shift_r;
  logic       cfg_we;
  logic       in_fire;
  logic       key_busy;
  key_t       key;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign busy      = key_busy;
  assign in_fire   = start && !busy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lang_r  <= 1'b0;
      dir_r   <= 1'b0;
      mult_r  <= 10'd1;
      shift_r <= 10'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LANGUAGE:   lang_r  <= cfg_data[0];
        REG_DIRECTION:  dir_r   <= cfg_data[0];
        REG_MULTIPLIER: mult_r  <= cfg_data;
        REG_SHIFT:      shift_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  aca_key_unit u_key (
    .clk    (clk),
    .rst_n  (rst_n),
    .reload (cfg_we),
    .lang   (lang_r),
    .mult   (mult_r),
    .shift  (shift_r),
    .key    (key),
    .busy   (key_busy)
  );

  aca_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_char    (in_char),
    .lang       (lang_r),
    .dir        (dir_r),
    .key        (key),
    .out_valid  (out_valid),
    .out_char   (out_char),
    .out_key_ok (out_key_ok)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_affine_cipher_alphabet_core.sv =====
`default_nettype none

module tb_affine_cipher_alphabet_core
  import aca_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int N_PHASES    = 16;
  localparam int PHASE_WORDS = 80;
  localparam int MAX_PRINTS  = 40;

  // Punctuation tail shared by both alphabets, in index order
  localparam logic [15:0] PUNCT [9] = '{CH_COMMA, CH_PERIOD, CH_SPACE, CH_EXCL, CH_QUEST,
                                       CH_SEMI, CH_COLON, CH_DQUOTE, CH_SQUOTE};

  typedef struct packed {
    logic [15:0] ch;
    logic        ok;
  } cipher_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] in_char = 16'h0000;
  logic        out_valid;
  logic [15:0] out_char;
  logic        out_key_ok;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_LANGUAGE;
  logic [9:0]  cfg_data = 10'd0;

  // Key copy used for prediction
  logic        k_lang = 1'b0;
  logic        k_dir = 1'b0;
  logic [9:0]  k_mult = 10'd1;
  logic [9:0]  k_shift = 10'd0;

  logic [15:0]  char_q[$];
  cipher_word_t cipher_exp_q[$];
  int           n_chars_queued = 0;
  int           n_chars_taken = 0;
  int           n_errors = 0;
  int           cyc = 0;
  logic         took = 1'b0;
  logic         draining = 1'b0;
  logic         calm = 1'b0;
  cipher_word_t got_exp;

  affine_cipher_alphabet_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_char   (in_char),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_key_ok(out_key_ok),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Position of a character in the active alphabet, 0 when absent
  function automatic int letter_index(logic [15:0] c);
    int base;
    base = k_lang ? 64 : 52;
    if (k_lang && c >= CH_CYR_LO0 && c <= CH_CYR_LO1) return int'(c - CH_CYR_LO0);
    if (k_lang && c >= CH_CYR_UP0 && c <= CH_CYR_UP1) return 32 + int'(c - CH_CYR_UP0);
    if (!k_lang && c >= CH_UP_A && c <= CH_UP_Z) return int'(c - CH_UP_A);
    if (!k_lang && c >= CH_LO_A && c <= CH_LO_Z) return 26 + int'(c - CH_LO_A);
    if (c >= CH_DIG_0 && c <= CH_DIG_9) return base + int'(c - CH_DIG_0);
    for (int i = 0; i < 9; i++) begin
      if (c == PUNCT[i]) return base + 10 + i;
    end
    return 0;
  endfunction

  // Character at a position of the active alphabet
  function automatic logic [15:0] letter_at(int pos);
    int base;
    base = k_lang ? 64 : 52;
    if (k_lang && pos < 32) return CH_CYR_LO0 + 16'(pos);
    if (k_lang && pos < 64) return CH_CYR_UP0 + 16'(pos - 32);
    if (!k_lang && pos < 26) return CH_UP_A + 16'(pos);
    if (!k_lang && pos < 52) return CH_LO_A + 16'(pos - 26);
    if (pos < base + 10) return CH_DIG_0 + 16'(pos - base);
    return PUNCT[pos - base - 10];
  endfunction

  // Expected output word for one input character under the current key
  function automatic cipher_word_t cipher_expect(logic [15:0] c);
    cipher_word_t w;
    int size;
    int a;
    int b;
    int t;
    int pos;
    int sh;
    int inv;
    int r;
    size = k_lang ? 83 : 71;
    a = int'(k_mult);
    b = size;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    w.ok = (a == 1);
    w.ch = 16'h0000;
    if (w.ok && c == CH_NEWLINE) begin
      w.ch = c;
    end else if (w.ok) begin
      pos = letter_index(c);
      sh = int'(k_shift) % size;
      if (!k_dir) begin
        r = (pos * (int'(k_mult) % size) + sh) % size;
      end else begin
        inv = 0;
        for (int x = 1; x < size; x++) begin
          if (inv == 0 && ((int'(k_mult) % size) * x) % size == 1) inv = x;
        end
        r = (inv * ((pos + size - sh) % size)) % size;
      end
      w.ch = letter_at(r);
    end
    return w;
  endfunction

  // Random character, mostly alphabet symbols of either language
  function automatic logic [15:0] pick_char();
    logic [15:0] near [8];
    near = '{CH_UP_A - 16'd1, CH_UP_Z + 16'd1, CH_LO_A - 16'd1, CH_LO_Z + 16'd1,
             CH_DIG_0 - 16'd1, CH_CYR_UP0 - 16'd1, CH_CYR_LO1 + 16'd1, CH_DIG_9 + 16'd1};
    case ($urandom_range(9))
      0:       return CH_UP_A + 16'($urandom_range(25));
      1:       return CH_LO_A + 16'($urandom_range(25));
      2:       return CH_DIG_0 + 16'($urandom_range(9));
      3:       return PUNCT[$urandom_range(8)];
      4:       return CH_NEWLINE;
      5:       return CH_CYR_LO0 + 16'($urandom_range(31));
      6:       return CH_CYR_UP0 + 16'($urandom_range(31));
      7:       return near[$urandom_range(7)];
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic queue_char(input logic [15:0] c);
    char_q = {char_q, c};
    n_chars_queued++;
  endtask

  // Wait until every queued word is taken and every result is back
  task automatic wait_drained();
    while (n_chars_taken != n_chars_queued || cipher_exp_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic key_write(input logic [1:0] idx, input logic [9:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_LANGUAGE:   k_lang = val[0];
      REG_DIRECTION:  k_dir = val[0];
      REG_MULTIPLIER: k_mult = val;
      REG_SHIFT:      k_shift = val;
      default:        ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= 10'($urandom);
  endtask

  // Sender: holds a word until taken, idles at random, pauses to drain now and then
  always @(negedge clk) begin
    if (rst_n) begin
      if (start && !took) begin
        // word still waiting on busy
      end else if (draining) begin
        start   <= 1'b0;
        in_char <= 16'($urandom);
        if (cipher_exp_q.size() == 0) draining <= 1'b0;
      end else if (char_q.size() != 0 && (calm || $urandom_range(99) >= 15)) begin
        start   <= 1'b1;
        in_char <= char_q.pop_front();
        if ($urandom_range(149) == 0) draining <= 1'b1;
      end else begin
        start   <= 1'b0;
        in_char <= 16'($urandom);
      end
    end
  end

  // Result check and prediction on each taken word
  always @(posedge clk) begin
    if (rst_n) begin
      took <= start && !busy;
      if (out_valid) begin
        if (cipher_exp_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word char=%h ok=%b", out_char, out_key_ok));
        end else begin
          got_exp = cipher_exp_q.pop_front();
          if (out_char !== got_exp.ch)
            flag_mismatch($sformatf("out_char %h, expected %h", out_char, got_exp.ch));
          if (out_key_ok !== got_exp.ok)
            flag_mismatch($sformatf("out_key_ok %b, expected %b", out_key_ok, got_exp.ok));
        end
      end
      if (start && !busy) begin
        cipher_exp_q = {cipher_exp_q, cipher_expect(in_char)};
        n_chars_taken++;
      end
    end else begin
      took <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("affine_cipher_alphabet_core verification failed");
      $finish;
    end
  end

  initial begin : stim
    logic       lang;
    logic       dir;
    logic [9:0] mult;
    logic [9:0] shft;
    int         rot;
    int         size;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset key: English, encode, identity; edges of each range
    queue_char(CH_UP_A);
    queue_char(CH_UP_Z);
    queue_char(CH_LO_A);
    queue_char(CH_LO_Z);
    queue_char(CH_DIG_0);
    queue_char(CH_DIG_9);
    queue_char(CH_COMMA);
    queue_char(CH_SQUOTE);
    queue_char(CH_SPACE);
    queue_char(CH_NEWLINE);
    queue_char(16'h0000);
    queue_char(16'hFFFF);
    queue_char(CH_CYR_LO0);
    queue_char(CH_CYR_LO1);
    queue_char(CH_CYR_UP0);
    queue_char(CH_CYR_UP1);
    queue_char(CH_UP_Z + 16'd1);
    queue_char(CH_UP_A - 16'd1);
    wait_drained();

    // Zero multiplier: key invalid, newline zeroed too
    key_write(REG_MULTIPLIER, 10'd0);
    queue_char(CH_NEWLINE);
    queue_char(CH_UP_A);
    queue_char(16'hFFFF);
    queue_char(CH_QUEST);
    wait_drained();

    for (int p = 0; p < N_PHASES; p++) begin
      lang = $urandom_range(1);
      dir  = $urandom_range(1);
      size = lang ? 83 : 71;
      case ($urandom_range(4))
        0:       mult = 10'd1;
        1:       mult = 10'd1023;
        2:       mult = 10'(size * $urandom_range(1023 / size));
        default: mult = 10'($urandom);
      endcase
      case ($urandom_range(3))
        0:       shft = 10'd0;
        1:       shft = 10'd1023;
        default: shft = 10'($urandom);
      endcase
      // fixed corners first
      case (p)
        0: begin lang = 1'b0; dir = 1'b0; mult = 10'd1023; shft = 10'd1023; end
        1: begin lang = 1'b1; dir = 1'b1; mult = 10'd1023; shft = 10'd1023; end
        2: begin lang = 1'b1; dir = 1'b0; mult = 10'd83;   shft = 10'd5;    end
        3: begin lang = 1'b0; dir = 1'b1; mult = 10'd994;  shft = 10'd0;    end
        4: begin lang = 1'b0; dir = 1'b1; mult = 10'd1;    shft = 10'd0;    end
        5: begin lang = 1'b1; dir = 1'b1; mult = 10'd2;    shft = 10'd82;   end
        default: ;
      endcase

      // all four registers, in rotating order; junk upper bits on 1-bit ones
      rot = $urandom_range(3);
      for (int k = 0; k < 4; k++) begin
        case (2'((rot + k) % 4))
          REG_LANGUAGE:   key_write(REG_LANGUAGE, {9'($urandom), lang});
          REG_DIRECTION:  key_write(REG_DIRECTION, {9'($urandom), dir});
          REG_MULTIPLIER: key_write(REG_MULTIPLIER, mult);
          REG_SHIFT:      key_write(REG_SHIFT, shft);
          default:        ;
        endcase
      end

      calm = (p == 5);
      for (int i = 0; i < PHASE_WORDS; i++) queue_char(pick_char());
      wait_drained();
      calm = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("affine_cipher_alphabet_core verification clean");
    end else begin
      $display("affine_cipher_alphabet_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
